### rtl/nmea_sentence_checker_unit_assert.svh
// Assertion macros for the NMEA sentence checker.
// No dependencies; taken in by the modules that assert.
`ifndef NMEA_SENTENCE_CHECKER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsc assertion failed");
`define NSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsc assertion failed");
`else
`define NSC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/nsc_pkg.sv
// Types, character codes and per-character scan function of the NMEA checker.
// No dependencies.
package nsc_pkg;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   localparam logic [23:0] NAME_GGA = 24'h474741;
   localparam logic [23:0] NAME_RMC = 24'h524D43;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_GGA  = 2'd1;
   localparam logic [1:0] KIND_RMC  = 2'd2;

   localparam logic [1:0] STAGE_BODY  = 2'd0;
   localparam logic [1:0] STAGE_STAR  = 2'd1;
   localparam logic [1:0] STAGE_ONE   = 2'd2;
   localparam logic [1:0] STAGE_MULTI = 2'd3;

   localparam logic [7:0] MIN_NAMED_LEN = 8'd9;
   localparam logic [4:0] HEX_OVF_COUNT = 5'd17;

   typedef struct packed {
      logic [7:0]  xor_sum;
      logic [1:0]  scan_stage;
      logic [7:0]  hex_low_byte;
      logic [4:0]  hex_digit_count;
      logic        hex_overflowed;
      logic        starts_with_dollar;
      logic [23:0] name_chars;
      logic [7:0]  text_length;
      logic        text_ended;
      logic        run_closed;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '0;

   typedef struct packed {
      logic [1:0] record_kind;
      logic       checksum_good;
      logic [6:0] sentence_length;
   } result_type;

   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] r;
      case (c) inside
         [8'h30:8'h39]: r = {1'b1, c[3:0]};
         [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
         [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
         default:       r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic line_state_type take_text(line_state_type s, logic [7:0] c);
      line_state_type r;
      logic [7:0]     pos;
      logic [4:0]     hx;
      logic [3:0]     d;
      r   = s;
      pos = s.text_length;
      hx  = hex_decode(c);
      d   = hx[3:0];
      if (!s.text_ended) begin
         if (c == CHAR_NUL) begin
            r.text_ended = 1'b1;
         end else begin
            if (s.text_length != 8'hFF) r.text_length = s.text_length + 8'd1;
            if (pos == 8'd0) begin
               r.starts_with_dollar = (c == CHAR_DOLLAR);
            end else begin
               if (pos == 8'd3) r.name_chars[23:16] = c;
               if (pos == 8'd4) r.name_chars[15:8]  = c;
               if (pos == 8'd5) r.name_chars[7:0]   = c;
               if (s.scan_stage == STAGE_BODY) begin
                  if (c == CHAR_STAR) r.scan_stage = STAGE_STAR;
                  else r.xor_sum = s.xor_sum ^ c;
               end else if (!s.run_closed) begin
                  if (!hx[4]) begin
                     r.run_closed = 1'b1;
                  end else begin
                     if (s.scan_stage != STAGE_MULTI) r.scan_stage = s.scan_stage + 2'd1;
                     if (!s.hex_overflowed) begin
                        if (s.hex_digit_count == 5'd0) begin
                           if (d != 4'd0) r.hex_digit_count = d[3] ? 5'd2 : 5'd1;
                        end else begin
                           r.hex_digit_count = s.hex_digit_count + 5'd1;
                        end
                        if (r.hex_digit_count >= HEX_OVF_COUNT) r.hex_overflowed = 1'b1;
                        r.hex_low_byte = {s.hex_low_byte[3:0], d};
                     end
                  end
               end
            end
         end
      end
      return r;
   endfunction

endpackage

### rtl/nsc_line_scan.sv
// Line state registers and per-byte update of the NMEA checker.
// Depends on nsc_pkg.
module nsc_line_scan #(
   parameter int LINE_CAPACITY = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  logic [7:0]          step_byte,
   output logic                result_valid,
   output nsc_pkg::result_type result
);

   localparam int HW = $clog2(LINE_CAPACITY + 1);
   localparam logic [HW-1:0] CAP = HW'(LINE_CAPACITY);

   logic [HW-1:0]           held_ff, held_in, held_base;
   logic                    cr_ff, cr_in;
   nsc_pkg::line_state_type line_ff, line_in, base, after_cr;
   logic                    full, is_nl, good;
   logic [7:0]              value;

   assign full      = (held_ff >= CAP);
   assign held_base = full ? '0 : held_ff;
   assign base      = full ? nsc_pkg::LINE_CLEAR : line_ff;
   assign is_nl     = (step_byte == nsc_pkg::CHAR_LF);
   assign after_cr  = (!full && cr_ff) ? nsc_pkg::take_text(base, nsc_pkg::CHAR_CR) : base;

   assign value = base.hex_overflowed ? 8'hFF : base.hex_low_byte;
   assign good  = base.starts_with_dollar && (base.scan_stage == nsc_pkg::STAGE_MULTI)
                  && (value == base.xor_sum);

   always_comb begin
      result.checksum_good   = good;
      result.sentence_length = base.text_length[7] ? 7'h7F : base.text_length[6:0];
      result.record_kind     = nsc_pkg::KIND_NONE;
      if (good && base.text_length >= nsc_pkg::MIN_NAMED_LEN) begin
         if (base.name_chars == nsc_pkg::NAME_GGA) result.record_kind = nsc_pkg::KIND_GGA;
         else if (base.name_chars == nsc_pkg::NAME_RMC) result.record_kind = nsc_pkg::KIND_RMC;
      end
   end

   assign result_valid = step_valid && is_nl;

   always_comb begin
      held_in = held_ff;
      cr_in   = cr_ff;
      line_in = line_ff;
      if (step_valid) begin
         if (is_nl) begin
            held_in = '0;
            cr_in   = 1'b0;
            line_in = nsc_pkg::LINE_CLEAR;
         end else begin
            held_in = held_base + HW'(1);
            if (step_byte == nsc_pkg::CHAR_CR) begin
               cr_in   = 1'b1;
               line_in = after_cr;
            end else begin
               cr_in   = 1'b0;
               line_in = nsc_pkg::take_text(after_cr, step_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         cr_ff   <= 1'b0;
         line_ff <= nsc_pkg::LINE_CLEAR;
      end else begin
         held_ff <= held_in;
         cr_ff   <= cr_in;
         line_ff <= line_in;
      end
   end

endmodule

### rtl/nmea_sentence_checker_unit.sv
// NMEA 0183 sentence checker top: input register, line scanner, result register.
// Depends on nsc_pkg, nsc_line_scan and nmea_sentence_checker_unit_assert.svh.
// Throughput: one byte per clock, but a newline byte waits in the input register
// while a full result register is not read; the line state updates once per byte.
// Reset (synchronous, active high) empties both registers and clears the line.
`include "nmea_sentence_checker_unit_assert.svh"
module nmea_sentence_checker_unit #(
   parameter int LINE_CAPACITY = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_record_kind,
   output logic       rsp_checksum_good,
   output logic [6:0] rsp_sentence_length
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                out_valid_ff, out_valid_in;
   nsc_pkg::result_type out_ff, out_in;
   nsc_pkg::result_type scan_result;
   logic                scan_valid, consume, in_is_nl, out_free;

   assign in_is_nl = (in_byte_ff == nsc_pkg::CHAR_LF);
   assign out_free = !out_valid_ff || rsp_ready;
   assign consume  = in_valid_ff && (!in_is_nl || out_free);
   assign req_ready = !in_valid_ff || consume;

   nsc_line_scan #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (consume),
      .step_byte    (in_byte_ff),
      .result_valid (scan_valid),
      .result       (scan_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
      if (scan_valid) begin
         out_valid_in = 1'b1;
         out_in       = scan_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_record_kind     = out_ff.record_kind;
   assign rsp_checksum_good   = out_ff.checksum_good;
   assign rsp_sentence_length = out_ff.sentence_length;

   `NSC_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !out_valid_ff && !scan_valid, !rsp_valid)
   `NSC_ASSERT_IMPLY(a_bad_sum_no_kind, clock, reset, rsp_valid && !rsp_checksum_good, rsp_record_kind == nsc_pkg::KIND_NONE)
   `NSC_ASSERT_IMPLY(a_kind_needs_len, clock, reset, rsp_valid && rsp_record_kind != nsc_pkg::KIND_NONE, rsp_sentence_length >= 7'd9)
   `NSC_ASSERT_NEXT(a_result_captured, clock, reset, scan_valid, rsp_valid)

endmodule

### test/tb.sv
// Testbench for nmea_sentence_checker_unit: byte stream in, one result per newline out.
// Depends on nsc_pkg and the RTL top; a built-in line predictor checks every result.
// Directed sentences first, then a random stream of framed and broken lines.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CAP       = 128;
   localparam int WATCHDOG_LIMIT = 2000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_record_kind;
   logic       rsp_checksum_good;
   logic [6:0] rsp_sentence_length;

   nmea_sentence_checker_unit #(.LINE_CAPACITY(LINE_CAP)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_record_kind     (rsp_record_kind),
      .rsp_checksum_good   (rsp_checksum_good),
      .rsp_sentence_length (rsp_sentence_length)
   );

   always #5 clock = ~clock;

   bit                  idle_on = 1'b1;
   int                  errors = 0;
   int unsigned         bytes_sent = 0;
   int unsigned         quiet_cycles = 0;
   nsc_pkg::result_type pending_results[$];

   // line predictor state
   int unsigned line_held;
   logic [7:0]  run_xor;
   logic [1:0]  hex_stage;
   logic [7:0]  hex_byte;
   logic [4:0]  sig_digits;
   logic        hex_big;
   logic        has_dollar;
   logic [23:0] id_chars;
   logic [7:0]  text_len;
   logic        text_done;
   logic        cr_held;
   logic        hex_closed;

   task automatic clear_sentence();
      line_held  = 0;
      run_xor    = 8'd0;
      hex_stage  = nsc_pkg::STAGE_BODY;
      hex_byte   = 8'd0;
      sig_digits = 5'd0;
      hex_big    = 1'b0;
      has_dollar = 1'b0;
      id_chars   = 24'd0;
      text_len   = 8'd0;
      text_done  = 1'b0;
      cr_held    = 1'b0;
      hex_closed = 1'b0;
   endtask

   function automatic int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
   endfunction

   task automatic absorb_char(input logic [7:0] c);
      logic [7:0] pos;
      int         digit;
      pos = text_len;
      if (text_done) return;
      if (c == nsc_pkg::CHAR_NUL) begin
         text_done = 1'b1;
         return;
      end
      if (text_len != 8'hFF) text_len = text_len + 8'd1;
      if (pos == 8'd0) begin
         has_dollar = (c == nsc_pkg::CHAR_DOLLAR);
         return;
      end
      case (pos)
         8'd3: id_chars[23:16] = c;
         8'd4: id_chars[15:8]  = c;
         8'd5: id_chars[7:0]   = c;
         default: ;
      endcase
      if (hex_stage == nsc_pkg::STAGE_BODY) begin
         if (c == nsc_pkg::CHAR_STAR) hex_stage = nsc_pkg::STAGE_STAR;
         else run_xor = run_xor ^ c;
         return;
      end
      if (hex_closed) return;
      digit = hex_of(c);
      if (digit < 0) begin
         hex_closed = 1'b1;
         return;
      end
      if (hex_stage != nsc_pkg::STAGE_MULTI) hex_stage = hex_stage + 2'd1;
      if (hex_big) return;
      if (sig_digits == 5'd0) begin
         if (digit != 0) sig_digits = (digit >= 8) ? 5'd2 : 5'd1;
      end else begin
         sig_digits = sig_digits + 5'd1;
      end
      if (sig_digits >= nsc_pkg::HEX_OVF_COUNT) hex_big = 1'b1;
      hex_byte = {hex_byte[3:0], 4'(digit)};
   endtask

   task automatic model_byte(input logic [7:0] c);
      logic [7:0]          sent_sum;
      logic                ok;
      nsc_pkg::result_type r;
      if (line_held >= LINE_CAP) clear_sentence();
      if (c == nsc_pkg::CHAR_LF) begin
         sent_sum = hex_big ? 8'hFF : hex_byte;
         ok = has_dollar && (hex_stage == nsc_pkg::STAGE_MULTI) && (sent_sum == run_xor);
         r.record_kind = nsc_pkg::KIND_NONE;
         if (ok && text_len >= nsc_pkg::MIN_NAMED_LEN) begin
            if (id_chars == nsc_pkg::NAME_GGA) r.record_kind = nsc_pkg::KIND_GGA;
            else if (id_chars == nsc_pkg::NAME_RMC) r.record_kind = nsc_pkg::KIND_RMC;
         end
         r.checksum_good   = ok;
         r.sentence_length = (text_len > 8'd127) ? 7'd127 : text_len[6:0];
         pending_results.push_back(r);
         clear_sentence();
         return;
      end
      line_held++;
      if (cr_held) begin
         cr_held = 1'b0;
         absorb_char(nsc_pkg::CHAR_CR);
      end
      if (c == nsc_pkg::CHAR_CR) cr_held = 1'b1;
      else absorb_char(c);
   endtask

   initial clear_sentence();

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(input string s, input bit with_cr);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      if (with_cr) send_byte(nsc_pkg::CHAR_CR);
      send_byte(nsc_pkg::CHAR_LF);
   endtask

   function automatic logic [7:0] fields_xor(string fields);
      logic [7:0] x;
      x = 8'd0;
      for (int i = 0; i < fields.len(); i++) x = x ^ fields[i];
      return x;
   endfunction

   function automatic string framed(string fields, bit lower_hex);
      if (lower_hex) return {"$", fields, $sformatf("*%02x", fields_xor(fields))};
      return {"$", fields, $sformatf("*%02X", fields_xor(fields))};
   endfunction

   function automatic string rand_hex_digits(int n);
      string pool;
      string r;
      pool = "0123456789abcdefABCDEF";
      r = "";
      for (int i = 0; i < n; i++) r = {r, $sformatf("%c", pool[$urandom_range(21)])};
      return r;
   endfunction

   task automatic test_named_sentences();
      send_line(framed("GPGGA,123519,4807.038,N,01131.000,E", 1'b0), 1'b1);
      send_line(framed("GNRMC,225446,A,4916.45,N", 1'b0), 1'b0);
      send_line(framed("GPGSV,1,1,08", 1'b1), 1'b1);
      send_line(framed("GPGGA", 1'b0), 1'b0);        // exactly nine characters
      send_line(framed("GPRM", 1'b0), 1'b0);         // too short to name
      send_line(framed("XXRMC,9", 1'b1), 1'b1);
   endtask

   task automatic test_checksum_errors();
      send_line($sformatf("$GPGGA,1*%02X", fields_xor("GPGGA,1") ^ 8'h01), 1'b0);
      send_line("$GPGGA,1,2,3", 1'b1);
      send_line($sformatf("$GPRMC,7*%1X", fields_xor("GPRMC,7") & 8'h0F), 1'b0);
      send_line($sformatf("!GPGGA,1*%02X", fields_xor("GPGGA,1")), 1'b0);
      send_line($sformatf("$GPGGA,1*G%02X", fields_xor("GPGGA,1")), 1'b0);
      send_line($sformatf("$GPRMC,5*%02Xzz,9", fields_xor("GPRMC,5")), 1'b1);
   endtask

   task automatic test_hex_run();
      send_line($sformatf("$GPGGA,1*7FFFFFFFFFFFFF%02X", fields_xor("GPGGA,1")), 1'b0);
      send_line($sformatf("$GPGGA,1*80000000000000%02X", fields_xor("GPGGA,1")), 1'b0);
      send_line($sformatf("$GPRMC,2*1000000000000000%02X", fields_xor("GPRMC,2")), 1'b0);
      send_line($sformatf("$GPRMC,3*00000000000000000000%02x", fields_xor("GPRMC,3")),
                1'b1);
   endtask

   task automatic test_line_endings();
      string s;
      send_byte(nsc_pkg::CHAR_LF);
      send_line(framed("GPGGA,1\015,2", 1'b0), 1'b0);  // carriage return inside text
      s = framed("GPRMC,4", 1'b0);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(nsc_pkg::CHAR_CR);
      send_byte(nsc_pkg::CHAR_CR);
      send_byte(nsc_pkg::CHAR_LF);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(nsc_pkg::CHAR_NUL);
      send_line("junk*00", 1'b0);
      send_byte(nsc_pkg::CHAR_NUL);
      send_line(s, 1'b0);
      send_byte(8'hFF);
      send_line(s, 1'b0);
   endtask

   task automatic test_line_overflow();
      repeat (LINE_CAP) send_byte("A");
      send_byte(nsc_pkg::CHAR_LF);
      repeat (LINE_CAP) send_byte("B");
      send_line(framed("GPGGA,5", 1'b0), 1'b1);
      repeat (LINE_CAP - 1) send_byte("C");
      send_byte(nsc_pkg::CHAR_LF);
      repeat (LINE_CAP - 2) send_byte("D");
      send_byte(nsc_pkg::CHAR_CR);
      send_byte(nsc_pkg::CHAR_LF);
   endtask

   task automatic send_random_sentence();
      string      fields;
      string      tail;
      string      lead;
      string      s;
      int         n;
      int         roll;
      int         nul_at;
      logic [7:0] sum;
      logic [7:0] c;
      roll = $urandom_range(9);
      if (roll < 4) fields = "GP";
      else if (roll < 7) fields = "GN";
      else fields = $sformatf("%c%c", 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)));
      roll = $urandom_range(9);
      if (roll < 4) fields = {fields, "GGA"};
      else if (roll < 8) fields = {fields, "RMC"};
      else fields = {fields, rand_hex_digits(3)};
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
      for (int i = 0; i < n; i++) begin
         c = 8'($urandom_range(32, 126));
         if (c == nsc_pkg::CHAR_STAR) c = ",";
         fields = {fields, $sformatf("%c", c)};
      end
      sum = fields_xor(fields);
      roll = $urandom_range(99);
      if (roll < 60) tail = $sformatf("*%02X", sum);
      else if (roll < 70) tail = $sformatf("*%02x", sum);
      else if (roll < 75) tail = $sformatf("*000%02X", sum);
      else if (roll < 80) tail = $sformatf("*%02X", sum ^ 8'($urandom_range(1, 255)));
      else if (roll < 85) tail = $sformatf("*%1X", sum[3:0]);
      else if (roll < 88) tail = "";
      else if (roll < 92) tail = $sformatf("*%02X%s", sum, rand_hex_digits(1));
      else if (roll < 96) tail = {"*", rand_hex_digits($urandom_range(14, 20))};
      else tail = $sformatf("*%02X,x", sum);
      if ($urandom_range(19) == 0) lead = "!";
      else lead = "$";
      s = {lead, fields, tail};
      nul_at = ($urandom_range(19) == 0) ? $urandom_range(0, s.len() - 1) : -1;
      for (int i = 0; i < s.len(); i++) begin
         if (i == nul_at) send_byte(nsc_pkg::CHAR_NUL);
         send_byte(s[i]);
      end
      roll = $urandom_range(2);
      if (roll >= 1) send_byte(nsc_pkg::CHAR_CR);
      if (roll == 2) send_byte(nsc_pkg::CHAR_CR);
      send_byte(nsc_pkg::CHAR_LF);
   endtask

   task automatic send_noise_line();
      int n;
      n = ($urandom_range(29) == 0) ? $urandom_range(130, 260) : $urandom_range(1, 40);
      repeat (n) send_byte(8'($urandom_range(255)));
      send_byte(nsc_pkg::CHAR_LF);
   endtask

   task automatic test_random_stream();
      int unsigned start;
      start = bytes_sent;
      for (int phase = 0; phase < 3; phase++) begin
         idle_on = (phase != 1);
         while (bytes_sent < start + 100 * (phase + 1)) begin
            if ($urandom_range(99) < 85) send_random_sentence();
            else send_noise_line();
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_named_sentences();
      test_checksum_errors();
      test_hex_run();
      test_line_endings();
      test_line_overflow();
      test_random_stream();
      finish_run();
   end

   always @(negedge clock) rsp_ready <= !idle_on || ($urandom_range(99) >= 34);

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      nsc_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %0d/%0d/%0d", $time,
                     rsp_record_kind, rsp_checksum_good, rsp_sentence_length);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("record_kind", want.record_kind, rsp_record_kind);
            check_field("checksum_good", want.checksum_good, rsp_checksum_good);
            check_field("sentence_length", want.sentence_length, rsp_sentence_length);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog timeout", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

### files.f
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_line_scan.sv
rtl/nmea_sentence_checker_unit.sv
test/tb.sv
